// ----- rtl/efd_pkg.sv -----
// ----------------------------------------------------------------------------
// efd_pkg
// Shared types and constants of the escaped frame deframer.
// ----------------------------------------------------------------------------
package efd_pkg;

  // framing bytes
  localparam logic [7:0] SYNC_BYTE   = 8'hCC;
  localparam logic [7:0] SYNC_SECOND = 8'h00;

  // configuration register indexes and reset values
  localparam logic       CFG_MAX_CHAN = 1'b0;
  localparam logic       CFG_MAX_PAY  = 1'b1;
  localparam logic [7:0]  RST_MAX_CHAN = 8'd32;
  localparam logic [15:0] RST_MAX_PAY  = 16'd128;

  // number of payload length bytes, big-endian
  localparam int unsigned PLEN_BYTES = 4;

  // parse phases
  typedef enum logic [2:0] {
    PH_HUNT_A = 3'd0,
    PH_HUNT_B = 3'd1,
    PH_CHLEN  = 3'd2,
    PH_PLEN   = 3'd3,
    PH_CHAN   = 3'd4,
    PH_PAY    = 3'd5,
    PH_CSUM   = 3'd6
  } phase_e;

  // result kinds
  typedef enum logic [1:0] {
    KIND_CHAN = 2'd0,
    KIND_PAY  = 2'd1,
    KIND_GOOD = 2'd2,
    KIND_BAD  = 2'd3
  } kind_e;

  // one result of the parser
  typedef struct packed {
    logic       valid;
    kind_e      kind;
    logic [7:0] data;
  } res_t;

endpackage

// ----- rtl/efd_byte_if.sv -----
// ----------------------------------------------------------------------------
// efd_byte_if
// Valid/ready channel carrying one raw received byte.
// ----------------------------------------------------------------------------
interface efd_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

// ----- rtl/efd_res_if.sv -----
// ----------------------------------------------------------------------------
// efd_res_if
// Valid/ready channel carrying one decoded byte or frame verdict.
// ----------------------------------------------------------------------------
interface efd_res_if;
  logic       valid;
  logic       ready;
  logic [1:0] out_kind;
  logic [7:0] out_byte;

  modport source (output valid, output out_kind, output out_byte, input ready);
  modport sink   (input valid, input out_kind, input out_byte, output ready);
endinterface

// ----- rtl/escaped_frame_deframer.sv -----
// ----------------------------------------------------------------------------
// escaped_frame_deframer
// Byte-stuffed serial frame deframer with an 8-bit additive checksum.
// An accepted byte sits in the input register, then goes through the parse logic
// into the result register; a full result register that is not being read stalls it.
// Throughput: one byte per cycle unless stalled; the parse state machine updates once per byte.
// Reset clears the parse state, the pipeline valids and loads the limits
// with 32 channel bytes and 128 payload bytes.
// ----------------------------------------------------------------------------
module escaped_frame_deframer (
  input  logic        clk_i,
  input  logic        rst_ni,
  efd_byte_if.sink    in_if,
  efd_res_if.source   out_if,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [15:0] cfg_data_i
);
  import efd_pkg::*;

  logic        in_valid_q;
  logic [7:0]  in_byte_q;
  logic [7:0]  max_chan_q;
  logic [15:0] max_pay_q;
  logic        res_valid_q;
  logic [1:0]  res_kind_q;
  logic [7:0]  res_byte_q;
  logic        step;
  logic        in_take;
  res_t        res;

  // the buffered byte moves on once the result register is free or being read
  assign step        = in_valid_q && (!res_valid_q || out_if.ready);
  assign in_take     = in_if.valid && in_if.ready;
  assign in_if.ready = !in_valid_q || step;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_take) begin
      in_valid_q <= 1'b1;
    end else if (step) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_byte_q <= in_if.rx_byte;
    end
  end

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_chan_q <= RST_MAX_CHAN;
      max_pay_q  <= RST_MAX_PAY;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_MAX_CHAN: max_chan_q <= cfg_data_i[7:0];
        CFG_MAX_PAY:  max_pay_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  efd_parser u_parser (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .step_i     (step),
    .rx_byte_i  (in_byte_q),
    .max_chan_i (max_chan_q),
    .max_pay_i  (max_pay_q),
    .res_o      (res)
  );

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (step) begin
      res_valid_q <= res.valid;
    end else if (out_if.ready) begin
      res_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step && res.valid) begin
      res_kind_q <= 2'(res.kind);
      res_byte_q <= res.data;
    end
  end

  assign out_if.valid    = res_valid_q;
  assign out_if.out_kind = res_kind_q;
  assign out_if.out_byte = res_byte_q;

endmodule

// ----- rtl/efd_parser.sv -----
// ----------------------------------------------------------------------------
// efd_parser
// Frame parse state machine: sync hunt, header lengths, unstuffing, checksum.
// ----------------------------------------------------------------------------
module efd_parser (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          step_i,
  input  logic [7:0]    rx_byte_i,
  input  logic [7:0]    max_chan_i,
  input  logic [15:0]   max_pay_i,
  output efd_pkg::res_t res_o
);
  import efd_pkg::*;

  localparam int unsigned IdxW = $clog2(PLEN_BYTES);
  localparam logic [IdxW-1:0] IdxLast = IdxW'(PLEN_BYTES - 1);

  phase_e          phase_q, phase_d;
  logic [IdxW-1:0] idx_q, idx_d;
  logic [7:0]      chan_rem_q, chan_rem_d;
  logic [15:0]     pay_rem_q, pay_rem_d;
  logic            pay_big_q, pay_big_d;
  logic [7:0]      sum_q, sum_d;
  logic            esc_q, esc_d;

  // shared decode of the incoming byte
  logic        is_sync, is_zero, in_body, take_body, broken, hdr_last, len_bad;
  logic [15:0] pay_shift;
  logic        pay_big_shift;

  assign is_sync       = (rx_byte_i == SYNC_BYTE);
  assign is_zero       = (rx_byte_i == SYNC_SECOND);
  assign in_body       = (phase_q == PH_CHAN) || (phase_q == PH_PAY);
  assign take_body     = in_body && (esc_q ? is_sync : !is_sync);
  assign broken        = in_body && esc_q && !is_sync;
  assign hdr_last      = (idx_q == IdxLast);
  assign pay_shift     = {pay_rem_q[7:0], rx_byte_i};
  assign pay_big_shift = pay_big_q || (pay_rem_q[15:8] != 8'd0);
  assign len_bad       = (chan_rem_q > max_chan_i) || pay_big_shift ||
                         (pay_shift > max_pay_i);

  // next phase
  always_comb begin
    phase_d = phase_q;
    case (phase_q)
      PH_HUNT_A: phase_d = is_sync ? PH_HUNT_B : PH_HUNT_A;
      PH_HUNT_B: phase_d = is_zero ? PH_CHLEN : PH_HUNT_A;
      PH_CHLEN:  phase_d = PH_PLEN;
      PH_PLEN: begin
        if (hdr_last) begin
          if (len_bad) begin
            phase_d = PH_HUNT_A;
          end else if (chan_rem_q != 8'd0) begin
            phase_d = PH_CHAN;
          end else begin
            phase_d = (pay_shift != 16'd0) ? PH_PAY : PH_CSUM;
          end
        end
      end
      PH_CHAN, PH_PAY: begin
        if (broken) begin
          phase_d = is_zero ? PH_CHLEN : PH_HUNT_A;
        end else if (take_body) begin
          if (phase_q == PH_CHAN) begin
            if (chan_rem_q == 8'd1) begin
              phase_d = (pay_rem_q != 16'd0) ? PH_PAY : PH_CSUM;
            end
          end else if (pay_rem_q == 16'd1) begin
            phase_d = PH_CSUM;
          end
        end
      end
      PH_CSUM:   phase_d = PH_HUNT_A;
      default:   phase_d = is_sync ? PH_HUNT_B : PH_HUNT_A;
    endcase
  end

  // datapath and result
  always_comb begin
    idx_d      = idx_q;
    chan_rem_d = chan_rem_q;
    pay_rem_d  = pay_rem_q;
    pay_big_d  = pay_big_q;
    sum_d      = sum_q;
    esc_d      = esc_q;
    res_o      = '{valid: 1'b0, kind: KIND_BAD, data: 8'd0};
    case (phase_q)
      PH_HUNT_B: begin
        if (is_zero) begin
          sum_d = 8'd0;
          esc_d = 1'b0;
        end
      end
      PH_CHLEN: begin
        chan_rem_d = rx_byte_i;
        idx_d      = '0;
        pay_rem_d  = 16'd0;
        pay_big_d  = 1'b0;
      end
      PH_PLEN: begin
        pay_rem_d = pay_shift;
        pay_big_d = pay_big_shift;
        idx_d     = idx_q + IdxW'(1);
        if (hdr_last) begin
          idx_d = '0;
          if (len_bad) begin
            res_o = '{valid: 1'b1, kind: KIND_BAD, data: 8'd0};
          end else begin
            sum_d = 8'd0;
            esc_d = 1'b0;
          end
        end
      end
      PH_CHAN, PH_PAY: begin
        if (broken) begin
          esc_d = 1'b0;
          res_o = '{valid: 1'b1, kind: KIND_BAD, data: 8'd0};
          if (is_zero) begin
            sum_d = 8'd0;
          end
        end else if (take_body) begin
          esc_d = 1'b0;
          sum_d = sum_q + rx_byte_i;
          if (phase_q == PH_CHAN) begin
            chan_rem_d = chan_rem_q - 8'd1;
            res_o      = '{valid: 1'b1, kind: KIND_CHAN, data: rx_byte_i};
          end else begin
            pay_rem_d = pay_rem_q - 16'd1;
            res_o     = '{valid: 1'b1, kind: KIND_PAY, data: rx_byte_i};
          end
        end else begin
          // unpaired sync byte inside the body, wait for its partner
          esc_d = 1'b1;
        end
      end
      PH_CSUM: begin
        res_o = '{valid: 1'b1, kind: (rx_byte_i == sum_q) ? KIND_GOOD : KIND_BAD,
                  data: 8'd0};
      end
      default: ;
    endcase
    if (!step_i) begin
      res_o.valid = 1'b0;
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_HUNT_A;
      idx_q      <= '0;
      chan_rem_q <= 8'd0;
      pay_rem_q  <= 16'd0;
      pay_big_q  <= 1'b0;
      sum_q      <= 8'd0;
      esc_q      <= 1'b0;
    end else if (step_i) begin
      phase_q    <= phase_d;
      idx_q      <= idx_d;
      chan_rem_q <= chan_rem_d;
      pay_rem_q  <= pay_rem_d;
      pay_big_q  <= pay_big_d;
      sum_q      <= sum_d;
      esc_q      <= esc_d;
    end
  end

`ifndef SYNTHESIS
  // channel phase always has bytes left to read
  a_chan_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_CHAN |-> chan_rem_q != 8'd0)
    else $error("channel phase with zero bytes left");

  // payload phase only with an accepted, nonzero length
  a_pay_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_PAY |-> (pay_rem_q != 16'd0) && !pay_big_q)
    else $error("payload phase with bad remaining count");

  // a pending escape exists only inside a frame body
  a_esc_body: assert property (@(posedge clk_i) disable iff (!rst_ni)
    esc_q |-> (phase_q == PH_CHAN) || (phase_q == PH_PAY))
    else $error("escape pending outside body");

  // a verdict always returns to hunting or a fresh header
  a_verdict_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid && (res_o.kind == KIND_GOOD || res_o.kind == KIND_BAD)
    |=> phase_q == PH_HUNT_A || phase_q == PH_CHLEN)
    else $error("verdict did not end the frame");
`endif

endmodule

// ----- dv/escaped_frame_deframer_tb.sv -----
// ----------------------------------------------------------------------------
// escaped_frame_deframer_tb
// Feeds byte-stuffed frames, clean and damaged, into the deframer under
// several length limit settings, predicts every decoded byte and verdict
// in a scoreboard, and checks the results in order with random stalls on
// both channels.
// ----------------------------------------------------------------------------
module escaped_frame_deframer_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import efd_pkg::*;

  localparam int unsigned HALF_PERIOD = 6;
  localparam int unsigned DRAIN_CYCLES = 8;
  localparam int unsigned STALL_LIMIT = 2000;
  localparam int unsigned HOLD_CYCLES = 200;
  localparam int unsigned HOLD_AT_RESULT = 40;
  localparam int unsigned MAX_GAP = 10;
  localparam int unsigned MAX_SHOWN = 10;

  // --------------------------------------------------------------------------
  // deframer predictor and store of decoded results still due
  // --------------------------------------------------------------------------
  class frame_scoreboard;
    typedef struct {
      kind_e      kind;
      logic [7:0] data;
    } decoded_t;

    logic [7:0]  max_chan;
    logic [15:0] max_pay;
    phase_e      phase;
    logic [2:0]  len_idx;
    logic [7:0]  chan_left;
    logic [31:0] pay_left;
    logic [7:0]  sum;
    bit          esc_held;
    decoded_t    due_q[$];
    int unsigned n_bytes;
    int unsigned n_results;
    int unsigned n_good;
    int unsigned n_bad;
    int unsigned n_fail;

    function new();
      max_chan  = RST_MAX_CHAN;
      max_pay   = RST_MAX_PAY;
      phase     = PH_HUNT_A;
      len_idx   = '0;
      chan_left = '0;
      pay_left  = '0;
      sum       = '0;
      esc_held  = 1'b0;
      n_bytes   = 0;
      n_results = 0;
      n_good    = 0;
      n_bad     = 0;
      n_fail    = 0;
    endfunction

    function void set_limit(logic idx, logic [15:0] value);
      if (idx == CFG_MAX_CHAN) max_chan = value[7:0];
      else max_pay = value;
    endfunction

    function void push(kind_e kind, logic [7:0] data);
      decoded_t d;
      d.kind = kind;
      d.data = data;
      due_q.push_back(d);
    endfunction

    function int unsigned pending();
      return due_q.size();
    endfunction

    function void report(string msg);
      n_fail++;
      if (n_fail <= MAX_SHOWN) $display("[%0t] %s", $realtime, msg);
    endfunction

    // decoded channel or payload byte: sum, count down, emit
    function void take_body(logic [7:0] b);
      sum = sum + b;
      if (phase == PH_CHAN) begin
        chan_left = chan_left - 8'd1;
        if (chan_left == 8'd0) phase = (pay_left != 32'd0) ? PH_PAY : PH_CSUM;
        push(KIND_CHAN, b);
      end else begin
        pay_left = pay_left - 32'd1;
        if (pay_left == 32'd0) phase = PH_CSUM;
        push(KIND_PAY, b);
      end
    endfunction

    // one accepted raw byte
    function void note_byte(logic [7:0] b);
      n_bytes++;
      case (phase)
        PH_HUNT_B: begin
          if (b == SYNC_SECOND) begin
            phase    = PH_CHLEN;
            sum      = '0;
            esc_held = 1'b0;
          end else begin
            phase = PH_HUNT_A;
          end
        end
        PH_CHLEN: begin
          chan_left = b;
          len_idx   = '0;
          pay_left  = '0;
          phase     = PH_PLEN;
        end
        PH_PLEN: begin
          pay_left = {pay_left[23:0], b};
          len_idx  = len_idx + 3'd1;
          if (len_idx == PLEN_BYTES) begin
            len_idx = '0;
            if (chan_left > max_chan || pay_left > {16'd0, max_pay}) begin
              phase = PH_HUNT_A;
              push(KIND_BAD, 8'd0);
            end else begin
              sum      = '0;
              esc_held = 1'b0;
              if (chan_left != 8'd0) phase = PH_CHAN;
              else phase = (pay_left != 32'd0) ? PH_PAY : PH_CSUM;
            end
          end
        end
        PH_CHAN, PH_PAY: begin
          if (esc_held) begin
            esc_held = 1'b0;
            if (b == SYNC_BYTE) begin
              take_body(b);
            end else begin
              // broken escape: the held sync byte opens a new frame if a second sync byte follows
              if (b == SYNC_SECOND) begin
                phase = PH_CHLEN;
                sum   = '0;
              end else begin
                phase = PH_HUNT_A;
              end
              push(KIND_BAD, 8'd0);
            end
          end else if (b == SYNC_BYTE) begin
            esc_held = 1'b1;
          end else begin
            take_body(b);
          end
        end
        PH_CSUM: begin
          phase = PH_HUNT_A;
          push((b == sum) ? KIND_GOOD : KIND_BAD, 8'd0);
        end
        default: begin
          phase = (b == SYNC_BYTE) ? PH_HUNT_B : PH_HUNT_A;
        end
      endcase
    endfunction

    // one accepted result against the oldest prediction
    function void check_result(logic [1:0] kind, logic [7:0] data);
      decoded_t d;
      n_results++;
      if (due_q.size() == 0) begin
        report($sformatf("unexpected result: kind %0d byte %02h", kind, data));
        return;
      end
      d = due_q.pop_front();
      if (d.kind == KIND_GOOD) n_good++;
      if (d.kind == KIND_BAD) n_bad++;
      if (kind !== d.kind || data !== d.data)
        report($sformatf("mismatch: expected kind %0d byte %02h, got kind %0d byte %02h",
                         d.kind, d.data, kind, data));
    endfunction

    function int unsigned close_out();
      if (due_q.size() != 0)
        report($sformatf("%0d results never arrived", due_q.size()));
      return n_fail;
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // clock, channels and block
  // --------------------------------------------------------------------------
  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic        cfg_idx_i;
  logic [15:0] cfg_data_i;

  efd_byte_if byte_ch ();
  efd_res_if  res_ch ();

  frame_scoreboard sb;
  logic [7:0]      frame_q[$];
  int unsigned     tx_count;
  int unsigned     n_settings;
  bit              tx_calm;

  always begin
    clk_i = 1'b0;
    #HALF_PERIOD;
    clk_i = 1'b1;
    #HALF_PERIOD;
  end

  escaped_frame_deframer u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_if      (byte_ch),
    .out_if     (res_ch),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  // --------------------------------------------------------------------------
  // byte sender; called and returns at a falling edge
  // --------------------------------------------------------------------------
  task automatic send_byte(input logic [7:0] b);
    int unsigned gap;
    if (tx_count % 40 == 0) tx_calm = ($urandom_range(0, 3) == 0);
    gap = tx_calm ? 0 : $urandom_range(0, MAX_GAP);
    if (gap > 0) begin
      byte_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    byte_ch.valid   <= 1'b1;
    byte_ch.rx_byte <= b;
    do @(posedge clk_i); while (!byte_ch.ready);
    sb.note_byte(b);
    tx_count++;
    @(negedge clk_i);
  endtask

  // let every due result and any byte still in flight come out
  task automatic drain();
    byte_ch.valid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  // both limit registers; channel data carries junk in its upper bits
  task automatic write_limits(input logic [7:0] chan, input logic [15:0] pay);
    logic [15:0] chan_word;
    chan_word = {8'($urandom_range(0, 255)), chan};
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= CFG_MAX_CHAN;
    cfg_data_i <= chan_word;
    sb.set_limit(CFG_MAX_CHAN, chan_word);
    @(negedge clk_i);
    cfg_idx_i  <= CFG_MAX_PAY;
    cfg_data_i <= pay;
    sb.set_limit(CFG_MAX_PAY, pay);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    n_settings++;
  endtask

  // --------------------------------------------------------------------------
  // one random frame, mostly well formed, into frame_q
  // --------------------------------------------------------------------------
  function automatic void build_frame();
    int unsigned lim_c, lim_p, damage, n_body, break_at;
    logic [7:0]  name_len, sum, b;
    logic [31:0] pay_len;
    bit          too_long;
    frame_q.delete();
    lim_c    = 32'(sb.max_chan);
    lim_p    = 32'(sb.max_pay);
    damage   = $urandom_range(0, 11);
    too_long = 1'b0;

    // leading noise or a bad second sync byte
    if (damage == 8)
      repeat ($urandom_range(1, 4)) frame_q.push_back(8'($urandom_range(0, 255)));
    if (damage == 9) begin
      frame_q.push_back(SYNC_BYTE);
      frame_q.push_back(8'($urandom_range(1, 255)));
    end

    // lengths, now and then past the limit, at times just past it
    name_len = 8'($urandom_range(0, (lim_c < 10) ? lim_c : 10));
    if (lim_c < 255 && $urandom_range(0, 9) == 0) begin
      name_len = 8'(($urandom_range(0, 1) != 0) ? lim_c + 1
                                                 : $urandom_range(lim_c + 1, 255));
      too_long = 1'b1;
    end
    pay_len = $urandom_range(0, (lim_p < 12) ? lim_p : 12);
    if ($urandom_range(0, 9) == 0) begin
      too_long = 1'b1;
      case ($urandom_range(0, 2))
        0: pay_len = lim_p + 1;
        1: pay_len = $urandom | 32'h0001_0000;
        default: pay_len = lim_p + $urandom_range(1, 1000);
      endcase
    end

    frame_q.push_back(SYNC_BYTE);
    frame_q.push_back(SYNC_SECOND);
    frame_q.push_back(name_len);
    frame_q.push_back(pay_len[31:24]);
    frame_q.push_back(pay_len[23:16]);
    frame_q.push_back(pay_len[15:8]);
    frame_q.push_back(pay_len[7:0]);
    if (too_long) return;

    // stuffed body, possibly cut by a broken escape
    n_body   = 32'(name_len) + pay_len;
    break_at = (damage == 7 && n_body > 0) ? $urandom_range(0, n_body - 1) : n_body;
    sum      = '0;
    for (int unsigned i = 0; i < n_body; i++) begin
      if (i == break_at) begin
        frame_q.push_back(SYNC_BYTE);
        b = 8'($urandom_range(0, 255));
        if (b == SYNC_BYTE) b = b ^ 8'h01;
        frame_q.push_back(($urandom_range(0, 1) != 0) ? SYNC_SECOND : b);
        return;
      end
      b = ($urandom_range(0, 5) == 0) ? SYNC_BYTE : 8'($urandom_range(0, 255));
      sum = sum + b;
      frame_q.push_back(b);
      if (b == SYNC_BYTE) frame_q.push_back(SYNC_BYTE);
    end
    frame_q.push_back((damage == 6) ? sum + 8'($urandom_range(1, 255)) : sum);
  endfunction

  task automatic random_frames(input int unsigned n_items);
    int unsigned start;
    start = tx_count;
    while (tx_count - start < n_items) begin
      build_frame();
      foreach (frame_q[i]) send_byte(frame_q[i]);
    end
  endtask

  // --------------------------------------------------------------------------
  // result receiver with one long hold-off to back the block up
  // --------------------------------------------------------------------------
  initial begin
    int unsigned gap, rx_count;
    bit          rx_calm;
    rx_count     = 0;
    rx_calm      = 1'b0;
    res_ch.ready = 1'b0;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      if (rx_count % 40 == 0) rx_calm = ($urandom_range(0, 3) == 0);
      gap = rx_calm ? 0 : $urandom_range(0, MAX_GAP);
      if (rx_count == HOLD_AT_RESULT) gap = HOLD_CYCLES;
      if (gap > 0) begin
        res_ch.ready <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      res_ch.ready <= 1'b1;
      do @(posedge clk_i); while (!res_ch.valid);
      sb.check_result(res_ch.out_kind, res_ch.out_byte);
      rx_count++;
      @(negedge clk_i);
    end
  end

  // --------------------------------------------------------------------------
  // watchdog on cycles with no transaction on either channel
  // --------------------------------------------------------------------------
  int unsigned idle_cycles;
  always @(posedge clk_i) begin
    if (!rst_ni || (byte_ch.valid && byte_ch.ready) || (res_ch.valid && res_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles + 1 >= STALL_LIMIT) begin
      $display("timeout: no transaction for %0d cycles", STALL_LIMIT);
      $display("Mismatches found");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // --------------------------------------------------------------------------
  // main sequence
  // --------------------------------------------------------------------------
  initial begin
    logic [7:0] directed_q[$];
    sb              = new();
    tx_count        = 0;
    n_settings      = 1;
    tx_calm         = 1'b0;
    idle_cycles     = 0;
    rst_ni          = 1'b0;
    byte_ch.valid   = 1'b0;
    byte_ch.rx_byte = '0;
    cfg_we_i        = 1'b0;
    cfg_idx_i       = CFG_MAX_CHAN;
    cfg_data_i      = '0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // good frame with an escaped sync byte and 0xff, checksum 0xcb
    directed_q = '{SYNC_BYTE, SYNC_SECOND, 8'h01, 8'h00, 8'h00, 8'h00, 8'h01,
                   SYNC_BYTE, SYNC_BYTE, 8'hFF, 8'hCB};
    // doubled sync byte is not a sync pair
    directed_q = {directed_q, SYNC_BYTE, SYNC_BYTE};
    // empty channel and payload, raw 0xcc checksum that does not match
    directed_q = {directed_q, SYNC_BYTE, SYNC_SECOND, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
                  SYNC_BYTE};
    // broken escape resyncs into a header whose payload length is too large
    directed_q = {directed_q, SYNC_BYTE, SYNC_SECOND, 8'h01, 8'h00, 8'h00, 8'h00, 8'h00,
                  SYNC_BYTE, SYNC_SECOND, 8'h00, 8'h00, 8'h00, 8'h01, 8'h00};
    foreach (directed_q[i]) send_byte(directed_q[i]);

    // reset limits, then tightest, widest, random and mid-range limits
    random_frames(70);
    drain();
    write_limits(8'd0, 16'd0);
    random_frames(70);
    drain();
    write_limits(8'd255, 16'hFFFF);
    random_frames(80);
    drain();
    write_limits(8'($urandom_range(0, 16)), 16'($urandom_range(0, 20)));
    random_frames(70);
    drain();
    write_limits(8'd8, 16'd300);
    random_frames(70);
    drain();

    $display("%0d raw bytes sent under %0d limit settings, %0d results checked",
             sb.n_bytes, n_settings, sb.n_results);
    $display("%0d frames passed the checksum, %0d were bad, too long or aborted",
             sb.n_good, sb.n_bad);
    if (sb.close_out() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
